>>> sv/bchb_pkg.sv
package bchb_pkg;

	localparam int COORD_W = 20;
	localparam int SUM_W = COORD_W + 1;
	localparam int DIM_REG_W = 9;
	localparam int EXT_W = 21;
	localparam int CFG_DATA_W = 21;
	localparam int CFG_INDEX_W = 2;
	localparam int POS_OUT_W = 8;
	localparam int CNT_OUT_W = 16;

	localparam int MAX_COLUMNS_DEF = 256;
	localparam int MAX_ROWS_DEF = 256;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [DIM_REG_W-1:0] GRID_COLUMNS_RST = DIM_REG_W'(256);
	localparam logic [DIM_REG_W-1:0] GRID_ROWS_RST = DIM_REG_W'(256);
	localparam logic [EXT_W-1:0] EXTENT_X_RST = EXT_W'(1048576);
	localparam logic [EXT_W-1:0] EXTENT_Z_RST = EXT_W'(1048576);

	localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLUMNS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_EXTENT_X = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_EXTENT_Z = 2'd3;

	localparam logic FUNC_CLEAR = 1'b0;
	localparam logic FUNC_ADD = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ROW_MUL,
		S_ROW_START,
		S_ROW_WAIT,
		S_COL_MUL,
		S_COL_START,
		S_COL_WAIT,
		S_ADDR_MUL,
		S_ADDR,
		S_READ,
		S_UPDATE
	} state_t;

endpackage

>>> sv/bchb_div.sv
module bchb_div #(
	parameter int NUM_W = 31,
	parameter int DEN_W = 22
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output logic             done
);

	localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		diff = trial - {1'b0, den_q};
		fits = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CNT_LAST) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign quo = quo_q;
	assign done = done_q;

endmodule

>>> sv/box_center_heatmap_binner_core.sv
// An add item steps through a row multiply and divide, a column multiply and divide,
// an address multiply, the address, a read and the update, and then strobes its result.
// Most of that time is spent in one shared restoring divider that yields one quotient bit a cycle.
// A clear item walks the whole store one entry a cycle and strobes after the last
// entry; busy falls with the strobe and the next item can be taken while it is high.
// Reset or a grid size write runs the same pass; results never stall.
module box_center_heatmap_binner_core #(
	parameter int MAX_COLUMNS = bchb_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS = bchb_pkg::MAX_ROWS_DEF,
	parameter int COUNT_BITS = bchb_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             func,
	input  logic [bchb_pkg::COORD_W-1:0]     low_x,
	input  logic [bchb_pkg::COORD_W-1:0]     high_x,
	input  logic [bchb_pkg::COORD_W-1:0]     low_z,
	input  logic [bchb_pkg::COORD_W-1:0]     high_z,
	input  logic                             cfg_write,
	input  logic [bchb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bchb_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                             done,
	output logic [bchb_pkg::POS_OUT_W-1:0]   bin_row,
	output logic [bchb_pkg::POS_OUT_W-1:0]   bin_col,
	output logic [bchb_pkg::CNT_OUT_W-1:0]   bin_count,
	output logic [bchb_pkg::CNT_OUT_W-1:0]   peak_count
);

	import bchb_pkg::*;

	localparam int HW = $clog2(MAX_ROWS + 1);
	localparam int WW = $clog2(MAX_COLUMNS + 1);
	localparam int DIMW = (HW > WW) ? HW : WW;
	localparam int PW = SUM_W + DIMW;
	localparam int NW = PW + 1;
	localparam int DEN_W = EXT_W + 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

	state_t state_q;
	state_t state_d;

	logic [DIM_REG_W-1:0] grid_columns_q;
	logic [DIM_REG_W-1:0] grid_rows_q;
	logic [EXT_W-1:0]     extent_x_q;
	logic [EXT_W-1:0]     extent_z_q;

	logic [DIMW-1:0]  h_eff;
	logic [DIMW-1:0]  w_eff;
	logic [EXT_W-1:0] ex_eff;
	logic [EXT_W-1:0] ez_eff;
	logic [DEN_W-1:0] den_x;
	logic [DEN_W-1:0] den_z;

	logic [SUM_W-1:0] sx_q;
	logic [SUM_W-1:0] sz_q;
	logic [PW-1:0]    prod_q;
	logic [RW-1:0]    row_q;
	logic [CW-1:0]    col_q;
	logic [AW-1:0]    addr_q;
	logic [AW-1:0]    clr_q;
	logic             clr_pend_q;
	logic [COUNT_BITS-1:0] peak_q;
	logic [COUNT_BITS-1:0] rd_q;
	logic [COUNT_BITS-1:0] cnt_new;
	logic [COUNT_BITS-1:0] peak_new;

	logic [COUNT_BITS-1:0] mem [DEPTH];

	logic [SUM_W-1:0] mul_a;
	logic [DIMW-1:0]  mul_b;
	logic [PW-1:0]    mul_p;
	logic             div_start;
	logic [NW-1:0]    div_num;
	logic [DEN_W-1:0] div_den;
	logic [NW-1:0]    div_quo;
	logic             div_done;
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	logic [COUNT_BITS-1:0] mem_wd;

	logic          cfg_clear;
	logic          accept;
	logic          clear_item;
	logic          clr_end;
	logic [NW-1:0] h_ext;
	logic [NW-1:0] w_ext;
	logic [NW-1:0] row_calc;
	logic [NW-1:0] col_calc;

	logic                 done_q;
	logic [POS_OUT_W-1:0] bin_row_q;
	logic [POS_OUT_W-1:0] bin_col_q;
	logic [CNT_OUT_W-1:0] bin_count_q;
	logic [CNT_OUT_W-1:0] peak_count_q;

	bchb_div #(
		.NUM_W(NW),
		.DEN_W(DEN_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.quo(div_quo),
		.done(div_done)
	);

	always_comb begin
		if (grid_rows_q == '0) begin
			h_eff = DIMW'(1);
		end else if (32'(grid_rows_q) > MAX_ROWS) begin
			h_eff = DIMW'(MAX_ROWS);
		end else begin
			h_eff = DIMW'(grid_rows_q);
		end
		if (grid_columns_q == '0) begin
			w_eff = DIMW'(1);
		end else if (32'(grid_columns_q) > MAX_COLUMNS) begin
			w_eff = DIMW'(MAX_COLUMNS);
		end else begin
			w_eff = DIMW'(grid_columns_q);
		end
		ex_eff = (extent_x_q == '0) ? EXT_W'(1) : extent_x_q;
		ez_eff = (extent_z_q == '0) ? EXT_W'(1) : extent_z_q;
		den_x = {ex_eff, 1'b0};
		den_z = {ez_eff, 1'b0};
		h_ext = NW'(h_eff);
		w_ext = NW'(w_eff);
	end

	always_comb begin
		cfg_clear = cfg_write && ((cfg_index == REG_GRID_COLUMNS) || (cfg_index == REG_GRID_ROWS));
		accept = start && (state_q == S_IDLE);
		clear_item = accept && (func == FUNC_CLEAR);
		clr_end = (state_q == S_CLEAR) && (clr_q == CLR_LAST);
	end

	always_comb begin
		if (div_quo >= h_ext) begin
			row_calc = '0;
		end else begin
			row_calc = h_ext - div_quo;
		end
		if (row_calc > h_ext - NW'(1)) begin
			row_calc = h_ext - NW'(1);
		end
		col_calc = (div_quo > w_ext - NW'(1)) ? (w_ext - NW'(1)) : div_quo;
		cnt_new = (&rd_q) ? rd_q : rd_q + COUNT_BITS'(1);
		peak_new = (cnt_new > peak_q) ? cnt_new : peak_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_d = (func == FUNC_ADD) ? S_ROW_MUL : S_CLEAR;
			end
			S_ROW_MUL: state_d = S_ROW_START;
			S_ROW_START: state_d = S_ROW_WAIT;
			S_ROW_WAIT: begin
				if (div_done) state_d = S_COL_MUL;
			end
			S_COL_MUL: state_d = S_COL_START;
			S_COL_START: state_d = S_COL_WAIT;
			S_COL_WAIT: begin
				if (div_done) state_d = S_ADDR_MUL;
			end
			S_ADDR_MUL: state_d = S_ADDR;
			S_ADDR: state_d = S_READ;
			S_READ: state_d = S_UPDATE;
			S_UPDATE: state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
		if (cfg_clear) state_d = S_CLEAR;
	end

	always_comb begin
		mul_a = sx_q;
		mul_b = h_eff;
		div_start = 1'b0;
		div_num = NW'(prod_q) + NW'(den_x) - NW'(1);
		div_den = den_x;
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = '0;
		unique case (state_q)
			S_CLEAR: mem_we = 1'b1;
			S_ROW_START: div_start = 1'b1;
			S_COL_MUL: begin
				mul_a = sz_q;
				mul_b = w_eff;
			end
			S_COL_START: begin
				div_start = 1'b1;
				div_num = NW'(prod_q);
				div_den = den_z;
			end
			S_ADDR_MUL: begin
				mul_a = SUM_W'(row_q);
				mul_b = w_eff;
			end
			S_UPDATE: begin
				mem_we = 1'b1;
				mem_wa = addr_q;
				mem_wd = cnt_new;
			end
			default: begin
			end
		endcase
		mul_p = PW'(mul_a) * PW'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			clr_pend_q <= 1'b0;
			peak_q <= '0;
			done_q <= 1'b0;
			grid_columns_q <= GRID_COLUMNS_RST;
			grid_rows_q <= GRID_ROWS_RST;
			extent_x_q <= EXTENT_X_RST;
			extent_z_q <= EXTENT_Z_RST;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == S_UPDATE) || (clr_end && clr_pend_q);
			if (cfg_write) begin
				unique case (cfg_index)
					REG_GRID_COLUMNS: grid_columns_q <= cfg_data[DIM_REG_W-1:0];
					REG_GRID_ROWS: grid_rows_q <= cfg_data[DIM_REG_W-1:0];
					REG_EXTENT_X: extent_x_q <= cfg_data[EXT_W-1:0];
					REG_EXTENT_Z: extent_z_q <= cfg_data[EXT_W-1:0];
					default: begin
					end
				endcase
			end
			if (cfg_clear || clear_item) begin
				clr_q <= '0;
				peak_q <= '0;
			end else if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end else if (state_q == S_UPDATE) begin
				peak_q <= peak_new;
			end
			if (clear_item) begin
				clr_pend_q <= 1'b1;
			end else if (clr_end && !cfg_clear) begin
				clr_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sx_q <= SUM_W'(low_x) + SUM_W'(high_x);
			sz_q <= SUM_W'(low_z) + SUM_W'(high_z);
		end
		if ((state_q == S_ROW_MUL) || (state_q == S_COL_MUL) || (state_q == S_ADDR_MUL)) begin
			prod_q <= mul_p;
		end
		if ((state_q == S_ROW_WAIT) && div_done) begin
			row_q <= RW'(row_calc);
		end
		if ((state_q == S_COL_WAIT) && div_done) begin
			col_q <= CW'(col_calc);
		end
		if (state_q == S_ADDR) begin
			addr_q <= prod_q[AW-1:0] + AW'(col_q);
		end
		if (state_q == S_UPDATE) begin
			bin_row_q <= POS_OUT_W'(row_q);
			bin_col_q <= POS_OUT_W'(col_q);
			bin_count_q <= CNT_OUT_W'(cnt_new);
			peak_count_q <= CNT_OUT_W'(peak_new);
		end else if (clr_end && clr_pend_q) begin
			bin_row_q <= '0;
			bin_col_q <= '0;
			bin_count_q <= '0;
			peak_count_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[addr_q];
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign bin_row = bin_row_q;
	assign bin_col = bin_col_q;
	assign bin_count = bin_count_q;
	assign peak_count = peak_count_q;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

import bchb_pkg::*;

typedef struct packed {
	logic [POS_OUT_W-1:0] row;
	logic [POS_OUT_W-1:0] col;
	logic [CNT_OUT_W-1:0] count;
	logic [CNT_OUT_W-1:0] peak;
} bin_update_t;

class heatmap_tally;
	bit [DIM_REG_W-1:0] grid_columns;
	bit [DIM_REG_W-1:0] grid_rows;
	bit [EXT_W-1:0] extent_x;
	bit [EXT_W-1:0] extent_z;
	bit [CNT_OUT_W-1:0] counts [MAX_ROWS_DEF*MAX_COLUMNS_DEF];
	bit [CNT_OUT_W-1:0] peak;
	bin_update_t expected_bins [$];
	int unsigned failures;

	function new();
		grid_columns = GRID_COLUMNS_RST;
		grid_rows = GRID_ROWS_RST;
		extent_x = EXTENT_X_RST;
		extent_z = EXTENT_Z_RST;
		failures = 0;
		wipe();
	endfunction

	function void wipe();
		foreach (counts[i]) counts[i] = '0;
		peak = '0;
	endfunction

	function int pending();
		return expected_bins.size();
	endfunction

	function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		case (index)
			REG_GRID_COLUMNS: begin
				grid_columns = value[DIM_REG_W-1:0];
				wipe();
			end
			REG_GRID_ROWS: begin
				grid_rows = value[DIM_REG_W-1:0];
				wipe();
			end
			REG_EXTENT_X: extent_x = value[EXT_W-1:0];
			REG_EXTENT_Z: extent_z = value[EXT_W-1:0];
			default: ;
		endcase
	endfunction

	function void note_box(logic f, logic [COORD_W-1:0] lx, logic [COORD_W-1:0] hx,
			logic [COORD_W-1:0] lz, logic [COORD_W-1:0] hz);
		longint unsigned w, h, ex, ez, sx, sz, den, up, row, col;
		int unsigned addr;
		bin_update_t r;
		r = '0;
		if (f == FUNC_CLEAR) begin
			wipe();
			expected_bins.push_back(r);
			return;
		end
		w = (grid_columns == 0) ? 1 :
			(grid_columns > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : grid_columns;
		h = (grid_rows == 0) ? 1 : (grid_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : grid_rows;
		ex = (extent_x == 0) ? 1 : extent_x;
		ez = (extent_z == 0) ? 1 : extent_z;
		sx = lx;
		sx = sx + hx;
		sz = lz;
		sz = sz + hz;
		den = 2 * ex;
		up = (sx * h + den - 1) / den;
		row = (up >= h) ? 0 : h - up;
		if (row > h - 1) row = h - 1;
		col = (sz * w) / (2 * ez);
		if (col > w - 1) col = w - 1;
		addr = 32'(row * w + col);
		if (counts[addr] != '1) counts[addr] = counts[addr] + 1'b1;
		if (counts[addr] > peak) peak = counts[addr];
		r.row = POS_OUT_W'(row);
		r.col = POS_OUT_W'(col);
		r.count = counts[addr];
		r.peak = peak;
		expected_bins.push_back(r);
	endfunction

	task report(string msg);
		failures++;
		$display("mismatch: %s", msg);
	endtask

	task check_bin(bin_update_t got);
		bin_update_t want;
		if (expected_bins.size() == 0) begin
			report($sformatf("result with nothing pending: row %0d col %0d count %0d",
				got.row, got.col, got.count));
			return;
		end
		want = expected_bins.pop_front();
		if (got.row !== want.row)
			report($sformatf("bin_row %0d, expected %0d", got.row, want.row));
		if (got.col !== want.col)
			report($sformatf("bin_col %0d, expected %0d", got.col, want.col));
		if (got.count !== want.count)
			report($sformatf("bin_count %0d, expected %0d", got.count, want.count));
		if (got.peak !== want.peak)
			report($sformatf("peak_count %0d, expected %0d", got.peak, want.peak));
	endtask

	task close_out();
		if (expected_bins.size() != 0)
			report($sformatf("%0d results never arrived", expected_bins.size()));
	endtask
endclass

module tb_top;
	localparam int unsigned LIMIT_CYCLES = 4000000;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic func;
	logic [COORD_W-1:0] low_x;
	logic [COORD_W-1:0] high_x;
	logic [COORD_W-1:0] low_z;
	logic [COORD_W-1:0] high_z;
	logic cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic done;
	logic [POS_OUT_W-1:0] bin_row;
	logic [POS_OUT_W-1:0] bin_col;
	logic [CNT_OUT_W-1:0] bin_count;
	logic [CNT_OUT_W-1:0] peak_count;

	heatmap_tally sb = new();
	int unsigned cycles = 0;
	int clears_left = 2;

	box_center_heatmap_binner_core uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_bin({bin_row, bin_col, bin_count, peak_count});
	end

	function automatic logic [COORD_W-1:0] pick_coord(input bit [EXT_W-1:0] ext);
		int unsigned top;
		top = (ext == 0) ? 1 : (ext > 21'hFFFFF) ? 32'hFFFFF : ext;
		case ($urandom_range(0, 9))
			0: return COORD_W'($urandom);
			1: return '0;
			2: return '1;
			default: return COORD_W'($urandom_range(0, top));
		endcase
	endfunction

	task automatic send_box(input logic f, input logic [COORD_W-1:0] lx,
			input logic [COORD_W-1:0] hx, input logic [COORD_W-1:0] lz,
			input logic [COORD_W-1:0] hz);
		start <= 1'b1;
		func <= f;
		low_x <= lx;
		high_x <= hx;
		low_z <= lz;
		high_z <= hz;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_box(f, lx, hx, lz, hz);
	endtask

	task automatic idle_gap();
		int unsigned pick, n;
		pick = $urandom_range(0, 99);
		if (pick < 50) n = 0;
		else if (pick < 85) n = $urandom_range(1, 3);
		else if (pick < 97) n = $urandom_range(4, 20);
		else n = $urandom_range(50, 200);
		if (n != 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic put_box(input logic f, input logic [COORD_W-1:0] lx,
			input logic [COORD_W-1:0] hx, input logic [COORD_W-1:0] lz,
			input logic [COORD_W-1:0] hz);
		send_box(f, lx, hx, lz, hz);
		idle_gap();
	endtask

	task automatic settle();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		while (busy !== 1'b0) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.set_register(index, value);
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	task automatic random_boxes(input int n);
		logic f;
		for (int i = 0; i < n; i++) begin
			f = FUNC_ADD;
			if (clears_left != 0 && $urandom_range(0, 59) == 0) begin
				f = FUNC_CLEAR;
				clears_left--;
			end
			send_box(f, pick_coord(sb.extent_x), pick_coord(sb.extent_x),
				pick_coord(sb.extent_z), pick_coord(sb.extent_z));
			if ($urandom_range(0, 39) == 0) settle();
			else idle_gap();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_ADD;
		low_x = '0;
		high_x = '0;
		low_z = '0;
		high_z = '0;
		cfg_write = 1'b0;
		cfg_index = REG_GRID_COLUMNS;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A zero center and a tiny center on x land in the same bottom row bin.
		put_box(FUNC_ADD, 20'h00000, 20'h00000, 20'h00000, 20'h00000);
		put_box(FUNC_ADD, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		put_box(FUNC_ADD, 20'h00000, 20'hFFFFF, 20'hFFFFF, 20'h00000);
		put_box(FUNC_ADD, 20'hAAAAA, 20'h55555, 20'h55555, 20'hAAAAA);
		put_box(FUNC_ADD, 20'h80000, 20'h80000, 20'h80000, 20'h80000);
		repeat (4) put_box(FUNC_ADD, 20'h00001, 20'h00000, 20'h00000, 20'h00001);
		put_box(FUNC_CLEAR, 20'hFFFFF, 20'h00000, 20'hFFFFF, 20'h00000);
		put_box(FUNC_ADD, 20'h00000, 20'h00000, 20'h00000, 20'h00000);
		put_box(FUNC_ADD, 20'h12345, 20'hEDCBA, 20'h0F0F0, 20'hF0F0F);
		random_boxes(110);
		settle();

		write_reg(REG_GRID_COLUMNS, CFG_DATA_W'(1));
		write_reg(REG_GRID_ROWS, CFG_DATA_W'(1));
		write_reg(REG_EXTENT_X, CFG_DATA_W'(1));
		write_reg(REG_EXTENT_Z, CFG_DATA_W'(1));
		put_box(FUNC_ADD, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		put_box(FUNC_ADD, 20'h00000, 20'h00000, 20'h00000, 20'h00000);
		put_box(FUNC_ADD, 20'h00001, 20'h00001, 20'h00001, 20'h00001);
		random_boxes(80);
		settle();

		write_reg(REG_GRID_COLUMNS, CFG_DATA_W'(0));
		write_reg(REG_GRID_ROWS, CFG_DATA_W'(511));
		write_reg(REG_EXTENT_X, CFG_DATA_W'(0));
		write_reg(REG_EXTENT_Z, 21'h1FFFFF);
		random_boxes(80);
		settle();

		write_reg(REG_GRID_COLUMNS, CFG_DATA_W'($urandom_range(2, 12)));
		write_reg(REG_GRID_ROWS, CFG_DATA_W'($urandom_range(2, 12)));
		write_reg(REG_EXTENT_X, CFG_DATA_W'($urandom_range(1, 1 << 20)));
		write_reg(REG_EXTENT_Z, CFG_DATA_W'($urandom_range(1, 1 << 20)));
		random_boxes(120);
		settle();

		write_reg(REG_GRID_COLUMNS, CFG_DATA_W'(256));
		write_reg(REG_EXTENT_X, CFG_DATA_W'(1 << 20));
		write_reg(REG_EXTENT_Z, CFG_DATA_W'(1));
		random_boxes(90);

		settle();
		repeat (200) @(posedge clk);
		sb.close_out();
		if (sb.failures == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
